### hw/rtl/assert_macros.svh
// Assertion macros shared by the framer checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define C16PF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("c16pf assertion failed");

// Clocked assertion that also holds during reset
`define C16PF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("c16pf reset assertion failed");

`endif

### hw/rtl/c16pf_pkg.sv
// Shared types and constants of the CRC-16 packet framer.
// No dependencies.
`default_nettype none

package c16pf_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;
  typedef logic [2:0]  cfg_index_t;

  // CRC-16/CCITT, MSB first, no reflection, no final xor
  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'h1021;

  // Register indexes of the configuration port
  localparam cfg_index_t REG_HEADER_FIRST  = 3'd0;
  localparam cfg_index_t REG_HEADER_SECOND = 3'd1;
  localparam cfg_index_t REG_FORMAT_VER    = 3'd2;
  localparam cfg_index_t REG_PACKET_LEN    = 3'd3;
  localparam cfg_index_t REG_MID_CRC_POS   = 3'd4;

  // Register reset values
  localparam byte_t RST_HEADER_FIRST  = 8'd0;
  localparam byte_t RST_HEADER_SECOND = 8'd0;
  localparam byte_t RST_FORMAT_VER    = 8'd2;
  localparam byte_t RST_PACKET_LEN    = 8'd64;
  localparam byte_t RST_MID_CRC_POS   = 8'd0;

endpackage

`default_nettype wire

### hw/rtl/c16pf_ifs.sv
// Handshake interfaces of the framer: payload input, framed output, register writes.
// Depends on c16pf_pkg.
`default_nettype none

interface c16pf_in_if;
  import c16pf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  logic  last_payload;
  modport source (output valid, payload_byte, last_payload, input ready);
  modport sink   (input valid, payload_byte, last_payload, output ready);
endinterface

interface c16pf_out_if;
  import c16pf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  end_of_packet;
  modport source (output valid, out_byte, end_of_packet, input ready);
  modport sink   (input valid, out_byte, end_of_packet, output ready);
endinterface

interface c16pf_cfg_if;
  import c16pf_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  byte_t      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/crc16_packet_framer_core.sv
// Top level of the CRC-16 packet framer: item register, word sequencer, output register.
// Depends on c16pf_pkg, c16pf_ifs and c16pf_crc_byte.
//
//  channel    dir  handshake     payload
//  byte_in    in   valid/ready   payload_byte[7:0], last_payload
//  frame_out  out  valid/ready   out_byte[7:0], end_of_packet
//  cfg        in   valid/ready   index[2:0], data[7:0]
//
// One word leaves the output register per cycle unless the output stalls (a rate set by
// the single output register); a payload byte emits its data word, led by the four header
// words if it opens a packet and two mid CRC words if inserted, then two CRC words if last.
// Reset (rst, synchronous) clears the sequencer and loads register defaults at once.
// A stalled output freezes the sequencer; byte_in.ready is high whenever the held item
// finishes this cycle or none is held. cfg.ready is always high.
`default_nettype none

module crc16_packet_framer_core (
  input  logic                clk,
  input  logic                rst,
  c16pf_in_if.sink            byte_in,
  c16pf_out_if.source         frame_out,
  c16pf_cfg_if.sink           cfg
);
  import c16pf_pkg::*;

  // Sequencer phase codes
  localparam logic [3:0] PH_FIRST = 4'd0;
  localparam logic [3:0] PH_HDR0  = 4'd1;
  localparam logic [3:0] PH_HDR1  = 4'd2;
  localparam logic [3:0] PH_VER   = 4'd3;
  localparam logic [3:0] PH_LEN   = 4'd4;
  localparam logic [3:0] PH_CHECK = 4'd5;
  localparam logic [3:0] PH_MIDLO = 4'd6;
  localparam logic [3:0] PH_MIDHI = 4'd7;
  localparam logic [3:0] PH_DATA  = 4'd8;
  localparam logic [3:0] PH_CRCLO = 4'd9;
  localparam logic [3:0] PH_CRCHI = 4'd10;

  // Configuration registers
  byte_t header_first;
  byte_t header_second;
  byte_t format_version;
  byte_t packet_length;
  byte_t mid_crc_position;

  // Held input item
  logic  hold_valid;
  byte_t hold_byte;
  logic  hold_last;

  // Framing state
  logic [3:0] phase;
  logic [3:0] phase_cur;
  logic [3:0] phase_after;
  logic       in_packet;
  byte_t      byte_position;
  crc_t       running_crc;
  byte_t      mid_crc_high;

  // Output register
  logic  out_valid;
  byte_t out_word;
  logic  out_eop;

  logic  emit;
  logic  item_done;
  logic  accept;
  logic  mid_hit;
  logic  covered;
  byte_t word_sel;
  crc_t  crc_fed;

  assign cfg.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first     <= RST_HEADER_FIRST;
      header_second    <= RST_HEADER_SECOND;
      format_version   <= RST_FORMAT_VER;
      packet_length    <= RST_PACKET_LEN;
      mid_crc_position <= RST_MID_CRC_POS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HEADER_FIRST:  header_first     <= cfg.data;
        REG_HEADER_SECOND: header_second    <= cfg.data;
        REG_FORMAT_VER:    format_version   <= cfg.data;
        REG_PACKET_LEN:    packet_length    <= cfg.data;
        REG_MID_CRC_POS:   mid_crc_position <= cfg.data;
        default: ;
      endcase
    end
  end

  assign mid_hit = (mid_crc_position != 8'd0) && (byte_position == mid_crc_position);

  // Resolve the phase that emits this cycle
  always_comb begin
    unique case (phase)
      PH_FIRST: begin
        if (!in_packet) begin
          phase_cur = PH_HDR0;
        end else if (mid_hit) begin
          phase_cur = PH_MIDLO;
        end else begin
          phase_cur = PH_DATA;
        end
      end
      PH_CHECK: phase_cur = mid_hit ? PH_MIDLO : PH_DATA;
      default:  phase_cur = phase;
    endcase
  end

  // Pick the word, its CRC coverage and the following phase
  always_comb begin
    word_sel    = hold_byte;
    covered     = 1'b0;
    phase_after = PH_FIRST;
    unique case (phase_cur)
      PH_HDR0: begin
        word_sel    = header_first;
        phase_after = PH_HDR1;
      end
      PH_HDR1: begin
        word_sel    = header_second;
        phase_after = PH_VER;
      end
      PH_VER: begin
        word_sel    = format_version;
        covered     = 1'b1;
        phase_after = PH_LEN;
      end
      PH_LEN: begin
        word_sel    = packet_length;
        covered     = 1'b1;
        phase_after = PH_CHECK;
      end
      PH_MIDLO: begin
        word_sel    = running_crc[7:0];
        covered     = 1'b1;
        phase_after = PH_MIDHI;
      end
      PH_MIDHI: begin
        word_sel    = mid_crc_high;
        covered     = 1'b1;
        phase_after = PH_DATA;
      end
      PH_DATA: begin
        word_sel    = hold_byte;
        covered     = 1'b1;
        phase_after = hold_last ? PH_CRCLO : PH_FIRST;
      end
      PH_CRCLO: begin
        word_sel    = running_crc[7:0];
        phase_after = PH_CRCHI;
      end
      PH_CRCHI: begin
        word_sel    = running_crc[15:8];
        phase_after = PH_FIRST;
      end
      default: ;
    endcase
  end

  c16pf_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (word_sel),
    .crc_out (crc_fed)
  );

  assign emit      = hold_valid && (!out_valid || frame_out.ready);
  assign item_done = ((phase_cur == PH_DATA) && !hold_last) || (phase_cur == PH_CRCHI);
  assign byte_in.ready = !hold_valid || (emit && item_done);
  assign accept    = byte_in.valid && byte_in.ready;

  // Hold the input item until its last word is emitted
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (emit && item_done) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= byte_in.payload_byte;
      hold_last <= byte_in.last_payload;
    end
  end

  // Advance phase and position on every emitted word, and the CRC on covered words
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      in_packet     <= 1'b0;
      byte_position <= 8'd0;
      running_crc   <= CRC_INIT;
    end else if (emit) begin
      phase <= item_done ? PH_FIRST : phase_after;
      if (phase_cur == PH_HDR0) begin
        in_packet     <= 1'b1;
        byte_position <= 8'd1;
        running_crc   <= CRC_INIT;
      end else if (phase_cur == PH_CRCHI) begin
        in_packet     <= 1'b0;
        byte_position <= 8'd0;
        running_crc   <= CRC_INIT;
      end else begin
        byte_position <= byte_position + 8'd1;
        if (covered) begin
          running_crc <= crc_fed;
        end
      end
    end
  end

  // Keep the high byte of the CRC as it stood before the inserted low byte
  always_ff @(posedge clk) begin
    if (emit && (phase_cur == PH_MIDLO)) begin
      mid_crc_high <= running_crc[15:8];
    end
  end

  // Load the output register, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (frame_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= word_sel;
      out_eop  <= (phase_cur == PH_CRCHI);
    end
  end

  assign frame_out.valid         = out_valid;
  assign frame_out.out_byte      = out_word;
  assign frame_out.end_of_packet = out_eop;

endmodule

`default_nettype wire

### hw/rtl/c16pf_crc_byte.sv
// Byte-wide CRC-16/CCITT update, MSB first, purely combinational.
// Depends on c16pf_pkg.
`default_nettype none

module c16pf_crc_byte (
  input  c16pf_pkg::crc_t  crc_in,
  input  c16pf_pkg::byte_t data,
  output c16pf_pkg::crc_t  crc_out
);
  import c16pf_pkg::*;

  crc_t c;

  // Fold the byte into the top and shift out eight bits
  always_comb begin
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

### hw/rtl/c16pf_checker.sv
// Port-level checker of the framer, bound to the top level.
// Depends on c16pf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module c16pf_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input c16pf_pkg::byte_t out_byte,
  input logic             out_eop
);
  import c16pf_pkg::*;

  logic       in_fire;
  logic       out_fire;
  logic [2:0] words_seen;
  logic [3:0] last_pending;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Count words since the last end of packet, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      words_seen <= 3'd0;
    end else if (out_fire) begin
      if (out_eop) begin
        words_seen <= 3'd0;
      end else if (words_seen != 3'd7) begin
        words_seen <= words_seen + 3'd1;
      end
    end
  end

  // Track last-marked input words not yet closed by an end of packet
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pending <= 4'd0;
    end else begin
      last_pending <= last_pending + {3'd0, in_fire && in_last}
                      - {3'd0, out_fire && out_eop};
    end
  end

  `C16PF_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_eop))
  `C16PF_ASSERT(a_eop_min_len, clk, rst, out_fire && out_eop |-> words_seen >= 3'd6)
  `C16PF_ASSERT(a_eop_after_last, clk, rst, out_fire && out_eop |-> last_pending != 4'd0)
  `C16PF_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid)

endmodule

bind crc16_packet_framer_core c16pf_checker u_c16pf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (byte_in.valid),
  .in_ready  (byte_in.ready),
  .in_last   (byte_in.last_payload),
  .out_valid (frame_out.valid),
  .out_ready (frame_out.ready),
  .out_byte  (frame_out.out_byte),
  .out_eop   (frame_out.end_of_packet)
);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking bench for crc16_packet_framer_core: header, pass-through, mid and trailing CRC.
// Depends on c16pf_pkg, the c16pf interfaces and the framer RTL.
// A byte-level framer model predicts every output word, and random stalls hit both sides.
`default_nettype none

module tb;
  import c16pf_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_WORDS   = 22;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  drain;
  } payload_word_t;

  typedef struct packed {
    byte_t data;
    logic  eop;
  } frame_word_t;

  logic clk;
  logic rst;

  c16pf_in_if  byte_in ();
  c16pf_out_if frame_out ();
  c16pf_cfg_if cfg ();

  crc16_packet_framer_core dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .frame_out (frame_out),
    .cfg       (cfg)
  );

  // Framer model: register copies and packet state
  byte_t hdr_first   = RST_HEADER_FIRST;
  byte_t hdr_second  = RST_HEADER_SECOND;
  byte_t fmt_version = RST_FORMAT_VER;
  byte_t pkt_length  = RST_PACKET_LEN;
  byte_t mid_pos     = RST_MID_CRC_POS;
  logic  open_pkt    = 1'b0;
  byte_t frame_pos   = 8'd0;
  crc_t  frame_crc   = CRC_INIT;

  frame_word_t   framed_due[$];
  payload_word_t payload_pending[$];

  int            fails;
  int            cycles;
  int            words_queued;
  int            words_taken;
  int            words_checked;
  int            packets_closed;
  int            settings;
  int            send_gap;
  int            stall_left;
  bit            send_idle;
  bit            recv_idle;
  logic          in_taken;
  payload_word_t next_word;
  frame_word_t   want;

  function automatic crc_t crc_next(crc_t crc, byte_t b);
    crc_t c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic int idle_len(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic byte_t pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Append one framed word to the due list and advance position and CRC
  task automatic emit_word(byte_t b, bit covered, bit eop);
    framed_due.push_back('{data: b, eop: eop});
    if (covered) frame_crc = crc_next(frame_crc, b);
    frame_pos = frame_pos + 8'd1;
  endtask

  // Work out the framed words that one accepted payload word causes
  task automatic frame_payload_word(byte_t data, logic last);
    crc_t snap;
    if (!open_pkt) begin
      open_pkt  = 1'b1;
      frame_pos = 8'd0;
      frame_crc = CRC_INIT;
      emit_word(hdr_first, 1'b0, 1'b0);
      emit_word(hdr_second, 1'b0, 1'b0);
      emit_word(fmt_version, 1'b1, 1'b0);
      emit_word(pkt_length, 1'b1, 1'b0);
    end
    if (mid_pos != 8'd0 && frame_pos == mid_pos) begin
      snap = frame_crc;
      emit_word(snap[7:0], 1'b1, 1'b0);
      emit_word(snap[15:8], 1'b1, 1'b0);
    end
    emit_word(data, 1'b1, 1'b0);
    if (last) begin
      snap = frame_crc;
      emit_word(snap[7:0], 1'b0, 1'b0);
      emit_word(snap[15:8], 1'b0, 1'b1);
      open_pkt  = 1'b0;
      frame_pos = 8'd0;
      frame_crc = CRC_INIT;
    end
  endtask

  task automatic apply_reg(cfg_index_t idx, byte_t val);
    case (idx)
      REG_HEADER_FIRST:  hdr_first = val;
      REG_HEADER_SECOND: hdr_second = val;
      REG_FORMAT_VER:    fmt_version = val;
      REG_PACKET_LEN:    pkt_length = val;
      REG_MID_CRC_POS:   mid_pos = val;
      default:           ;
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample handshakes: predict on accepted payload words, check framed words
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= byte_in.valid && byte_in.ready;
      if (cfg.valid && cfg.ready) apply_reg(cfg.index, cfg.data);
      if (byte_in.valid && byte_in.ready) begin
        frame_payload_word(byte_in.payload_byte, byte_in.last_payload);
        words_taken++;
      end
      if (frame_out.valid && frame_out.ready) begin
        words_checked++;
        if (framed_due.size() == 0) begin
          $error("unexpected framed word: out_byte %02h end_of_packet %b",
                 frame_out.out_byte, frame_out.end_of_packet);
          fails++;
        end else begin
          want = framed_due.pop_front();
          if (frame_out.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, frame_out.out_byte);
            fails++;
          end
          if (frame_out.end_of_packet !== want.eop) begin
            $error("end_of_packet: expected %b, got %b", want.eop, frame_out.end_of_packet);
            fails++;
          end
          if (want.eop) packets_closed++;
        end
      end
    end
  end

  // Payload driver: advance on acceptance, insert gaps, hold for drain requests
  always @(negedge clk) begin
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else if (in_taken || !byte_in.valid) begin
      if (send_gap > 0) begin
        send_gap--;
        byte_in.valid <= 1'b0;
      end else if (payload_pending.size() != 0 &&
                   !(payload_pending[0].drain && framed_due.size() != 0)) begin
        next_word = payload_pending.pop_front();
        byte_in.valid        <= 1'b1;
        byte_in.payload_byte <= next_word.data;
        byte_in.last_payload <= next_word.last;
        send_gap = idle_len(send_idle);
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  // Output sink: random backpressure
  always @(negedge clk) begin
    if (rst) begin
      frame_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      frame_out.ready <= 1'b0;
    end else begin
      frame_out.ready <= 1'b1;
      if (recv_idle && $urandom_range(0, 99) < 35) stall_left = idle_len(1'b1);
    end
  end

  task automatic write_reg(cfg_index_t idx, byte_t val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic write_all(byte_t hf, byte_t hs, byte_t ver, byte_t len, byte_t mid);
    write_reg(REG_HEADER_FIRST, hf);
    write_reg(REG_HEADER_SECOND, hs);
    write_reg(REG_FORMAT_VER, ver);
    write_reg(REG_PACKET_LEN, len);
    write_reg(REG_MID_CRC_POS, mid);
    settings++;
  endtask

  task automatic queue_word(byte_t data, logic last, logic drain);
    payload_pending.push_back('{data: data, last: last, drain: drain});
    words_queued++;
  endtask

  // Random-content packet; optionally left open for the next phase
  task automatic queue_packet(int len, bit closes);
    for (int i = 0; i < len; i++) begin
      queue_word(pick_byte(), closes && (i == len - 1), $urandom_range(0, 19) == 0);
    end
  endtask

  // Wait until every word is accepted and every framed word has come out
  task automatic settle();
    while (words_taken != words_queued || framed_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    byte_t mid;
    int    budget;
    int    len;

    byte_in.valid        = 1'b0;
    byte_in.payload_byte = 8'h00;
    byte_in.last_payload = 1'b0;
    cfg.valid            = 1'b0;
    cfg.index            = REG_HEADER_FIRST;
    cfg.data             = 8'h00;
    frame_out.ready      = 1'b0;
    send_idle            = 1'b0;
    recv_idle            = 1'b0;
    rst                  = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset register values; second packet waits for the first to drain
    queue_word(8'h00, 1'b1, 1'b0);
    queue_word(8'hFF, 1'b0, 1'b1);
    queue_word(8'h80, 1'b0, 1'b0);
    queue_word(8'h01, 1'b1, 1'b0);
    settle();

    // All-ones and all-zeros registers, mid position inside the header
    write_all(8'hFF, 8'h00, 8'hFF, 8'h00, 8'd2);
    queue_word(8'h55, 1'b0, 1'b0);
    queue_word(8'hAA, 1'b1, 1'b0);
    settle();

    // Mid CRC right on the first payload slot
    send_idle = 1'b1;
    recv_idle = 1'b1;
    write_all(8'hA5, 8'h5A, 8'd3, 8'd62, 8'd4);
    queue_word(8'h12, 1'b1, 1'b0);
    queue_word(8'h34, 1'b0, 1'b0);
    queue_word(8'h56, 1'b1, 1'b0);
    settle();

    // Last byte on the mid slot, then a packet that ends short of it, then one left open
    write_reg(REG_MID_CRC_POS, 8'd6);
    settings++;
    queue_word(8'h01, 1'b0, 1'b0);
    queue_word(8'h02, 1'b0, 1'b0);
    queue_word(8'h03, 1'b1, 1'b0);
    queue_word(8'h04, 1'b0, 1'b0);
    queue_word(8'h05, 1'b1, 1'b0);
    queue_word(8'h77, 1'b0, 1'b0);
    settle();

    // Change registers inside the open packet; the new mid slot is hit next
    write_reg(REG_MID_CRC_POS, 8'd5);
    write_reg(REG_HEADER_FIRST, 8'h3C);
    settings++;
    queue_word(8'h88, 1'b0, 1'b0);
    queue_word(8'h99, 1'b1, 1'b0);
    settle();

    // Random phases: random registers, random packets, some left open across phases
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 5))
        0:       mid = 8'd0;
        1:       mid = byte_t'($urandom_range(1, 3));
        2:       mid = byte_t'($urandom_range(4, 12));
        3:       mid = 8'd62;
        4:       mid = 8'd255;
        default: mid = byte_t'($urandom_range(0, 255));
      endcase
      send_idle = (p != 0) && ($urandom_range(0, 3) != 0);
      recv_idle = (p != 0) && ($urandom_range(0, 3) != 0);
      write_all(pick_byte(), pick_byte(), pick_byte(), pick_byte(), mid);
      budget = 0;
      while (budget < PHASE_WORDS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 8);
          7, 8:                len = $urandom_range(9, 20);
          default: begin
            len = (mid == 8'd62) ? $urandom_range(57, 61) : $urandom_range(1, 4);
          end
        endcase
        budget += len;
        queue_packet(len, (budget < PHASE_WORDS) || ($urandom_range(0, 9) < 7));
      end
      settle();
    end

    $display("run: %0d payload words in, %0d framed words checked, %0d packets closed",
             words_taken, words_checked, packets_closed);
    $display("run: %0d register settings, incl. mid CRC off, in header, on last byte",
             settings);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
